FILE: rtl/indexed_deque_engine_defines.svh
// Assertion macros shared by the indexed deque engine RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef INDEXED_DEQUE_ENGINE_DEFINES_SVH
`define INDEXED_DEQUE_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/ide_pkg.sv
// Package for the indexed deque engine: request and result types,
// operation and status codes, cell command codes. Depends on nothing.
`default_nettype none

package ide_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 64;

  localparam int OP_W     = 4;
  localparam int POS_W    = 7;
  localparam int POS2_W   = 6;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
  localparam logic [OP_W-1:0] OP_READ       = 4'd6;
  localparam logic [OP_W-1:0] OP_WRITE      = 4'd7;
  localparam logic [OP_W-1:0] OP_SWAP       = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [POS_W-1:0]   position;
    logic [POS2_W-1:0]  second_position;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  element_count;
  } rsp_t;

  // Command broadcast to every cell of the chain at once.
  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_t;

endpackage

`default_nettype wire

FILE: rtl/ide_cell.sv
// One storage cell of the deque chain: an element register and a read bus stage.
// Depends on ide_pkg for the cell command codes.
`default_nettype none

module ide_cell import ide_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire cell_op_t              cmd,
  input  wire logic [IDX_W-1:0]      pos,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  input  wire logic [DATA_WIDTH-1:0] bus_in,
  output logic      [DATA_WIDTH-1:0] data,
  output logic      [DATA_WIDTH-1:0] bus_out
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (IDX_W'(INDEX) == pos);
  assign above_pos = (IDX_W'(INDEX) > pos);

  always_ff @(posedge clk) begin
    unique case (cmd)
      CELL_NOP: ;
      CELL_INSERT: begin
        // Cells behind the gap take their left neighbor; the gap takes the new value.
        if (above_pos) data <= left_data;
        else if (at_pos) data <= wdata;
      end
      CELL_REMOVE: begin
        if (above_pos || at_pos) data <= right_data;
      end
      CELL_WRITE: begin
        if (at_pos) data <= wdata;
      end
      CELL_LOAD: begin
        bus_out <= at_pos ? data : '0;
      end
      CELL_SHIFT: begin
        // The read bus moves one cell toward the front each cycle.
        bus_out <= bus_in;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/indexed_deque_engine.sv
// Top level of the indexed deque engine: sequencer, count and the cell chain.
// Depends on ide_pkg, ide_cell and indexed_deque_engine_defines.svh.
`default_nettype none

`include "indexed_deque_engine_defines.svh"

// Holds up to CAPACITY elements in a row of cells, index 0 in the first cell.
// A request is taken when start is high and busy is low; its result appears
// on result for one cycle with done high, and must be taken then. Push,
// insert, remove and write shift or update all cells in parallel in the
// execute state, which also registers the result. Read, pop front and pop
// back copy the selected cell (position 0 for pop front, count - 1 for pop
// back) onto a registered read bus that moves one cell toward the front per
// cycle. Swap runs two such reads and two writes. Erroneous requests leave
// the cells as they are and go straight to the execute state.
module indexed_deque_engine import ide_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output logic      done,
  output rsp_t      result
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SHIFT,
    S_EXEC,
    S_EXEC2
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count_q;
  logic [OP_W-1:0]       op_q;
  logic [STATUS_W-1:0]   status_q;
  logic [IDX_W-1:0]      pos_q;
  logic [IDX_W-1:0]      pos2_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] hold_a;
  logic [IDX_W-1:0]      shift_cnt;
  logic                  second_pass;

  // Request decode against the current count.
  logic [CMP_W-1:0]    p1_ext;
  logic [CMP_W-1:0]    p2_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                full;
  logic                empty;
  logic                p1_bad;
  logic                p2_bad;
  logic                ins_bad;
  logic [STATUS_W-1:0] acc_status;
  logic [CMP_W-1:0]    acc_pos;
  logic                acc_read;

  assign p1_ext  = CMP_W'(request.position);
  assign p2_ext  = CMP_W'(request.second_position);
  assign cnt_ext = CMP_W'(count_q);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign p1_bad  = (p1_ext >= cnt_ext);
  assign p2_bad  = (p2_ext >= cnt_ext);
  assign ins_bad = (p1_ext > cnt_ext);

  always_comb begin
    acc_status = ST_OK;
    acc_pos    = p1_ext;
    acc_read   = 1'b0;
    unique case (request.operation)
      OP_PUSH_FRONT: begin
        if (full) acc_status = ST_FULL;
        acc_pos = '0;
      end
      OP_PUSH_BACK: begin
        if (full) acc_status = ST_FULL;
        acc_pos = cnt_ext;
      end
      OP_POP_FRONT: begin
        if (empty) acc_status = ST_EMPTY;
        acc_pos  = '0;
        acc_read = 1'b1;
      end
      OP_POP_BACK: begin
        if (empty) acc_status = ST_EMPTY;
        acc_pos  = cnt_ext - CMP_W'(1);
        acc_read = 1'b1;
      end
      OP_INSERT: begin
        if (ins_bad) acc_status = ST_RANGE;
        else if (full) acc_status = ST_FULL;
      end
      OP_REMOVE, OP_WRITE: begin
        if (p1_bad) acc_status = ST_RANGE;
      end
      OP_READ: begin
        if (p1_bad) acc_status = ST_RANGE;
        acc_read = 1'b1;
      end
      OP_SWAP: begin
        if (p1_bad || p2_bad) acc_status = ST_RANGE;
        acc_read = 1'b1;
      end
      default: acc_status = ST_RANGE;
    endcase
  end

  // Cell chain.
  cell_op_t              cell_cmd;
  logic [IDX_W-1:0]      cell_pos;
  logic [DATA_WIDTH-1:0] cell_wdata;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_bus  [CAPACITY+1];
  logic [IDX_W-1:0]      load_pos;
  logic [DATA_WIDTH-1:0] bus0;

  assign cell_bus[CAPACITY] = '0;
  assign bus0     = cell_bus[0];
  assign load_pos = second_pass ? pos2_q : pos_q;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_inner_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_inner_r
        assign right_d = cell_data[gi+1];
      end
      ide_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W),
        .INDEX      (gi)
      ) u_cell (
        .clk        (clk),
        .cmd        (cell_cmd),
        .pos        (cell_pos),
        .wdata      (cell_wdata),
        .left_data  (left_d),
        .right_data (right_d),
        .bus_in     (cell_bus[gi+1]),
        .data       (cell_data[gi]),
        .bus_out    (cell_bus[gi])
      );
    end
  endgenerate

  always_comb begin
    cell_cmd   = CELL_NOP;
    cell_pos   = pos_q;
    cell_wdata = val_q;
    unique case (state)
      S_IDLE: ;
      S_LOAD: begin
        cell_cmd = CELL_LOAD;
        cell_pos = load_pos;
      end
      S_SHIFT: cell_cmd = CELL_SHIFT;
      S_EXEC: begin
        if (status_q == ST_OK) begin
          unique case (op_q)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: cell_cmd = CELL_INSERT;
            OP_POP_FRONT, OP_REMOVE: cell_cmd = CELL_REMOVE;
            OP_WRITE: cell_cmd = CELL_WRITE;
            OP_SWAP: begin
              // Second read done: the value from the second index goes to the first.
              if (second_pass) begin
                cell_cmd   = CELL_WRITE;
                cell_wdata = bus0;
              end
            end
            default: cell_cmd = CELL_NOP;
          endcase
        end
      end
      S_EXEC2: begin
        cell_cmd   = CELL_WRITE;
        cell_pos   = pos2_q;
        cell_wdata = hold_a;
      end
      default: cell_cmd = CELL_NOP;
    endcase
  end

  // Result of the request in flight.
  logic             grows;
  logic             shrinks;
  logic             returns_value;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    grows         = 1'b0;
    shrinks       = 1'b0;
    returns_value = 1'b0;
    if (status_q == ST_OK) begin
      unique case (op_q)
        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: grows = 1'b1;
        OP_POP_FRONT, OP_POP_BACK: begin
          shrinks       = 1'b1;
          returns_value = 1'b1;
        end
        OP_REMOVE: shrinks = 1'b1;
        OP_READ:   returns_value = 1'b1;
        default: ;
      endcase
    end
    if (grows) count_next = count_q + CNT_W'(1);
    else if (shrinks) count_next = count_q - CNT_W'(1);
    else count_next = count_q;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      count_q     <= '0;
      second_pass <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op_q        <= request.operation;
            status_q    <= acc_status;
            pos_q       <= acc_pos[IDX_W-1:0];
            pos2_q      <= p2_ext[IDX_W-1:0];
            val_q       <= request.value[DATA_WIDTH-1:0];
            second_pass <= 1'b0;
            state       <= (acc_status == ST_OK && acc_read) ? S_LOAD : S_EXEC;
          end
        end
        S_LOAD: begin
          done      <= 1'b0;
          shift_cnt <= load_pos;
          state     <= (load_pos == '0) ? S_EXEC : S_SHIFT;
        end
        S_SHIFT: begin
          done      <= 1'b0;
          shift_cnt <= shift_cnt - IDX_W'(1);
          if (shift_cnt == IDX_W'(1)) state <= S_EXEC;
        end
        S_EXEC: begin
          if (status_q == ST_OK && op_q == OP_SWAP && !second_pass) begin
            done        <= 1'b0;
            hold_a      <= bus0;
            second_pass <= 1'b1;
            state       <= S_LOAD;
          end else if (status_q == ST_OK && op_q == OP_SWAP) begin
            done  <= 1'b0;
            state <= S_EXEC2;
          end else begin
            done                 <= 1'b1;
            count_q              <= count_next;
            result.status        <= status_q;
            result.read_value    <= returns_value ? VALUE_W'(bus0) : '0;
            result.element_count <= COUNT_W'(count_next);
            state                <= S_IDLE;
          end
        end
        S_EXEC2: begin
          done                 <= 1'b1;
          result.status        <= status_q;
          result.read_value    <= '0;
          result.element_count <= COUNT_W'(count_q);
          state                <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPLY(a_count_cap, clk, rst, 1'b1, count_q <= CNT_W'(CAPACITY))
  `ASSERT_IMPLY(a_empty_zero, clk, rst, done && result.status == ST_EMPTY, count_q == '0)
  `ASSERT_IMPLY(a_full_cap, clk, rst, done && result.status == ST_FULL,
                count_q == CNT_W'(CAPACITY))

endmodule

`default_nettype wire
